// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// concurrent assertion that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/ecgrpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecgrpm_pkg;

  localparam int unsigned ValW      = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IdxW      = 32;
  localparam int unsigned CntW      = 16;
  localparam int unsigned ThrW      = 15;
  localparam int unsigned GapW      = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAmpThreshold = 3'd0,
    CfgMinPeakGap   = 3'd1,
    CfgMinIndexGap  = 3'd2,
    CfgLongInterval = 3'd3,
    CfgFlatLimit    = 3'd4,
    CfgFlatMinPeaks = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]  amplitude_threshold;
    logic [CntW-1:0]  min_peak_gap_ms;
    logic [GapW-1:0]  min_index_gap;
    logic [CntW-1:0]  long_interval_ms;
    logic [CntW-1:0]  flatline_limit;
    logic [GapW-1:0]  flatline_min_peaks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    amplitude_threshold: 15'd1024,
    min_peak_gap_ms:     16'd50,
    min_index_gap:       8'd2,
    long_interval_ms:    16'd1100,
    flatline_limit:      16'd4000,
    flatline_min_peaks:  8'd4
  };

  typedef struct packed {
    logic signed [ValW-1:0] sample_value;
    logic [TimeW-1:0]       sample_time_ms;
    logic                   end_of_record;
  } sample_t;

  typedef struct packed {
    logic                   peak_opened;
    logic                   peak_updated;
    logic [CntW-1:0]        peak_total;
    logic [TimeW-1:0]       peak_time_ms;
    logic signed [ValW-1:0] peak_value;
    logic [CntW-1:0]        long_gap_total;
    logic                   flatline_alarm;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/ecgrpm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ecgrpm_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ecgrpm_pkg::ValW-1:0]    sample_value;
  logic [ecgrpm_pkg::TimeW-1:0]          sample_time_ms;
  logic                                  end_of_record;

  modport source (output valid, sample_value, sample_time_ms, end_of_record, input ready);
  modport sink   (input valid, sample_value, sample_time_ms, end_of_record, output ready);
endinterface

interface ecgrpm_result_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  peak_opened;
  logic                                  peak_updated;
  logic [ecgrpm_pkg::CntW-1:0]           peak_total;
  logic [ecgrpm_pkg::TimeW-1:0]          peak_time_ms;
  logic signed [ecgrpm_pkg::ValW-1:0]    peak_value;
  logic [ecgrpm_pkg::CntW-1:0]           long_gap_total;
  logic                                  flatline_alarm;

  modport source (output valid, peak_opened, peak_updated, peak_total, peak_time_ms,
                  peak_value, long_gap_total, flatline_alarm, input ready);
  modport sink   (input valid, peak_opened, peak_updated, peak_total, peak_time_ms,
                  peak_value, long_gap_total, flatline_alarm, output ready);
endinterface

interface ecgrpm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ecgrpm_pkg::CfgIdxW-1:0]        index;
  logic [ecgrpm_pkg::CfgDataW-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ecg_r_peak_rhythm_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// ECG R-peak rhythm monitor. Takes one timestamped sample word per cycle on sample_i and
// returns exactly one result word per sample on result_o, in order. A sample is captured in
// an input register and evaluated against the rhythm state by combinational compare and
// counter logic. The result lands in an output register, which offers it on result_o.
// Throughput is one sample per cycle while result_o is not stalled, since each sample
// depends on the state left by the one before. While a finished result waits to be taken,
// the input register takes one more sample; sample_i.ready then stays low until
// result_o.ready returns. Registers on cfg_i are always ready and should only be written
// while no sample is in flight.
module ecg_r_peak_rhythm_monitor (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ecgrpm_cfg_if.sink        cfg_i,
  ecgrpm_sample_if.sink     sample_i,
  ecgrpm_result_if.source   result_o
);

  ecgrpm_pkg::cfg_t    cfg;
  ecgrpm_pkg::sample_t in_q;
  ecgrpm_pkg::result_t res, res_q;
  logic                in_vld_q, out_vld_q;
  logic                fire, in_take;

  assign fire    = in_vld_q && (!out_vld_q || result_o.ready);
  assign in_take = sample_i.valid && sample_i.ready;
  assign sample_i.ready = !in_vld_q || fire;

  ecgrpm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ecgrpm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (in_q),
    .fire_i   (fire),
    .result_o (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.sample_value   <= sample_i.sample_value;
      in_q.sample_time_ms <= sample_i.sample_time_ms;
      in_q.end_of_record  <= sample_i.end_of_record;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || result_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.peak_opened    = res_q.peak_opened;
  assign result_o.peak_updated   = res_q.peak_updated;
  assign result_o.peak_total     = res_q.peak_total;
  assign result_o.peak_time_ms   = res_q.peak_time_ms;
  assign result_o.peak_value     = res_q.peak_value;
  assign result_o.long_gap_total = res_q.long_gap_total;
  assign result_o.flatline_alarm = res_q.flatline_alarm;

endmodule

`default_nettype wire

// File: hw/rtl/ecgrpm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ecgrpm_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ecgrpm_cfg_if.sink             cfg_i,
  output ecgrpm_pkg::cfg_t       cfg_o
);

  ecgrpm_pkg::cfg_t cfg_q, cfg_d;
  ecgrpm_pkg::cfg_idx_e idx;

  assign cfg_i.ready = 1'b1;
  assign idx = ecgrpm_pkg::cfg_idx_e'(cfg_i.index);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (idx)
        ecgrpm_pkg::CfgAmpThreshold:
          cfg_d.amplitude_threshold = cfg_i.data[ecgrpm_pkg::ThrW-1:0];
        ecgrpm_pkg::CfgMinPeakGap:   cfg_d.min_peak_gap_ms  = cfg_i.data;
        ecgrpm_pkg::CfgMinIndexGap:
          cfg_d.min_index_gap = cfg_i.data[ecgrpm_pkg::GapW-1:0];
        ecgrpm_pkg::CfgLongInterval: cfg_d.long_interval_ms = cfg_i.data;
        ecgrpm_pkg::CfgFlatLimit:    cfg_d.flatline_limit   = cfg_i.data;
        ecgrpm_pkg::CfgFlatMinPeaks:
          cfg_d.flatline_min_peaks = cfg_i.data[ecgrpm_pkg::GapW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ecgrpm_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/ecgrpm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ecgrpm_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ecgrpm_pkg::cfg_t    cfg_i,
  input  wire ecgrpm_pkg::sample_t sample_i,
  input  wire logic                fire_i,
  output ecgrpm_pkg::result_t      result_o
);

  localparam int unsigned TW = ecgrpm_pkg::TimeW;
  localparam int unsigned CW = ecgrpm_pkg::CntW;

  // rhythm state
  logic                               primed_q;
  logic signed [ecgrpm_pkg::ValW-1:0] prev_q;
  logic [ecgrpm_pkg::IdxW-1:0]        counter_q, counter_d;
  logic [CW-1:0]                      pc_q, pc_d;
  logic [TW-1:0]                      cur_time_q, cur_time_d;
  logic [ecgrpm_pkg::IdxW-1:0]        cur_idx_q, cur_idx_d;
  logic signed [ecgrpm_pkg::ValW-1:0] cur_amp_q, cur_amp_d;
  logic [TW-1:0]                      prior_q, prior_d, prior_mid;
  logic [CW-1:0]                      lg_q, lg_d, lg_mid;
  logic [CW-1:0]                      zc_q, zc_d, zc_inc;

  logic signed [ecgrpm_pkg::ValW-1:0] v;
  logic [TW-1:0]                      t;
  logic                               eor;
  logic [ecgrpm_pkg::IdxW-1:0]        k;
  logic                               rise, tgap, igap, open_new;
  logic                               ivl_open, ivl_eor, zero_hit, alarm;

  function automatic logic long_ivl(input logic [CW-1:0] pc, input logic [TW-1:0] cur,
                                    input logic [TW-1:0] prior, input logic [CW-1:0] lim);
    logic [TW-1:0] diff;
    diff = cur - prior;
    return (pc >= CW'(2)) && (cur >= prior) && (diff > TW'(lim));
  endfunction

  assign v   = sample_i.sample_value;
  assign t   = sample_i.sample_time_ms;
  assign eor = sample_i.end_of_record;
  assign k   = counter_q + 1'b1;

  assign rise = primed_q && (v > prev_q) &&
                ($signed({v[ecgrpm_pkg::ValW-1], v}) >
                 $signed({2'b00, cfg_i.amplitude_threshold}));
  assign tgap = (t >= cur_time_q) && ((t - cur_time_q) > TW'(cfg_i.min_peak_gap_ms));
  assign igap = (k - cur_idx_q) > ecgrpm_pkg::IdxW'(cfg_i.min_index_gap);
  assign open_new = rise && ((pc_q == '0) || (tgap && igap));

  // interval closed by a new peak
  assign ivl_open  = long_ivl(pc_q, cur_time_q, prior_q, cfg_i.long_interval_ms);
  assign lg_mid    = (open_new && ivl_open && (lg_q != '1)) ? lg_q + 1'b1 : lg_q;
  assign prior_mid = (open_new && (pc_q != '0)) ? cur_time_q : prior_q;
  assign pc_d      = (open_new && (pc_q != '1)) ? pc_q + 1'b1 : pc_q;

  assign cur_time_d = rise ? t : cur_time_q;
  assign cur_amp_d  = rise ? v : cur_amp_q;
  assign cur_idx_d  = rise ? k : cur_idx_q;
  assign counter_d  = primed_q ? k : '0;

  // interval closed by end of record
  assign ivl_eor = long_ivl(pc_d, cur_time_d, prior_mid, cfg_i.long_interval_ms);
  assign lg_d    = (eor && ivl_eor && (lg_mid != '1)) ? lg_mid + 1'b1 : lg_mid;
  assign prior_d = eor ? cur_time_d : prior_mid;

  // flatline
  assign zero_hit = (pc_d > CW'(cfg_i.flatline_min_peaks)) && (v == '0);
  assign zc_inc   = (zc_q != '1) ? zc_q + 1'b1 : zc_q;
  assign alarm    = zero_hit && (zc_inc > cfg_i.flatline_limit);
  assign zc_d     = alarm ? '0 : (zero_hit ? zc_inc : zc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      prev_q     <= '0;
      counter_q  <= '0;
      pc_q       <= '0;
      cur_time_q <= '0;
      cur_idx_q  <= '0;
      cur_amp_q  <= '0;
      prior_q    <= '0;
      lg_q       <= '0;
      zc_q       <= '0;
    end else if (fire_i) begin
      primed_q   <= 1'b1;
      prev_q     <= v;
      counter_q  <= counter_d;
      pc_q       <= pc_d;
      cur_time_q <= cur_time_d;
      cur_idx_q  <= cur_idx_d;
      cur_amp_q  <= cur_amp_d;
      prior_q    <= prior_d;
      lg_q       <= lg_d;
      zc_q       <= zc_d;
    end
  end

  always_comb begin
    result_o.peak_opened    = open_new;
    result_o.peak_updated   = rise;
    result_o.peak_total     = pc_d;
    result_o.peak_time_ms   = cur_time_d;
    result_o.peak_value     = cur_amp_d;
    result_o.long_gap_total = lg_d;
    result_o.flatline_alarm = alarm;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ecgrpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ecgrpm_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic                               peak_opened_i,
  input wire logic                               peak_updated_i,
  input wire logic signed [ecgrpm_pkg::ValW-1:0] peak_value_i,
  input wire logic [ecgrpm_pkg::CntW-1:0]        peak_total_i
);

  // a new peak always moves the current peak
  `ASSERT_RST(a_open_updates, clk_i, rst_ni, (out_valid_i && peak_opened_i) |-> peak_updated_i)

  // a peak sample lies above a non-negative threshold
  `ASSERT_RST(a_peak_positive, clk_i, rst_ni,
              (out_valid_i && peak_updated_i) |->
              (!peak_value_i[ecgrpm_pkg::ValW-1] && (peak_value_i != '0)))

  // stalled word holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni,
              (out_valid_i && !out_ready_i) |=>
              (out_valid_i && $stable(peak_total_i) && $stable(peak_value_i)))

  // nothing is offered straight after reset
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind ecg_r_peak_rhythm_monitor ecgrpm_checker u_ecgrpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .peak_opened_i  (result_o.peak_opened),
  .peak_updated_i (result_o.peak_updated),
  .peak_value_i   (result_o.peak_value),
  .peak_total_i   (result_o.peak_total)
);

`default_nettype wire

// File: bench/ecgrpm_rhythm_check.sv
`timescale 1ns / 1ps

module ecgrpm_rhythm_check (
  input  logic     clk,
  input  logic     rst_n,
  ecgrpm_cfg_if    cfg_mon,
  ecgrpm_sample_if smp_mon,
  ecgrpm_result_if res_mon,
  output int       fail_count,
  output int       pending
);
  import ecgrpm_pkg::*;

  cfg_t                   regs;
  logic signed [ValW-1:0] prev_val;
  logic                   primed;
  logic [IdxW-1:0]        sample_idx;
  logic [IdxW-1:0]        cur_idx;
  logic [CntW-1:0]        peak_cnt;
  logic [CntW-1:0]        long_gaps;
  logic [CntW-1:0]        zero_cnt;
  logic [TimeW-1:0]       cur_time;
  logic [TimeW-1:0]       prior_time;
  logic signed [ValW-1:0] cur_amp;
  result_t                rhythm_q[$];
  int                     words_seen;

  function automatic string fmt_result(result_t r);
    return $sformatf("opened=%0b updated=%0b peaks=%0d time=%0d value=%0d long=%0d alarm=%0b",
                     r.peak_opened, r.peak_updated, r.peak_total, r.peak_time_ms,
                     $signed(r.peak_value), r.long_gap_total, r.flatline_alarm);
  endfunction

  task automatic close_rr_interval();
    logic [TimeW-1:0] rr;
    rr = cur_time - prior_time;
    if (peak_cnt >= 2 && cur_time >= prior_time && rr > TimeW'(regs.long_interval_ms) &&
        long_gaps != '1) begin
      long_gaps++;
    end
  endtask

  task automatic step_rhythm(input sample_t s, output result_t r);
    logic signed [ValW-1:0] v;
    logic [TimeW-1:0]       t;
    logic [TimeW-1:0]       dt;
    logic [IdxW-1:0]        k;
    logic [IdxW-1:0]        di;
    logic                   open_new;
    v = s.sample_value;
    t = s.sample_time_ms;
    r = '0;
    if (!primed) begin
      primed = 1'b1;
      sample_idx = '0;
    end else begin
      k = sample_idx + 1;
      sample_idx = k;
      if (v > prev_val && int'(v) > int'(regs.amplitude_threshold)) begin
        dt = t - cur_time;
        di = k - cur_idx;
        open_new = (peak_cnt == 0) ||
                   (t >= cur_time && dt > TimeW'(regs.min_peak_gap_ms) &&
                    di > IdxW'(regs.min_index_gap));
        if (open_new) begin
          close_rr_interval();
          if (peak_cnt != 0) prior_time = cur_time;
          if (peak_cnt != '1) peak_cnt++;
          r.peak_opened = 1'b1;
        end
        cur_time = t;
        cur_amp = v;
        cur_idx = k;
        r.peak_updated = 1'b1;
      end
    end
    prev_val = v;
    if (s.end_of_record) begin
      close_rr_interval();
      prior_time = cur_time;
    end
    if (peak_cnt > CntW'(regs.flatline_min_peaks) && v == 0) begin
      if (zero_cnt != '1) zero_cnt++;
      if (zero_cnt > regs.flatline_limit) begin
        r.flatline_alarm = 1'b1;
        zero_cnt = '0;
      end
    end
    r.peak_total = peak_cnt;
    r.peak_time_ms = cur_time;
    r.peak_value = cur_amp;
    r.long_gap_total = long_gaps;
  endtask

  always @(posedge clk or negedge rst_n) begin
    sample_t w;
    result_t exp_r;
    result_t got;
    if (!rst_n) begin
      regs = CfgReset;
      prev_val = '0;
      primed = 1'b0;
      sample_idx = '0;
      cur_idx = '0;
      peak_cnt = '0;
      long_gaps = '0;
      zero_cnt = '0;
      cur_time = '0;
      prior_time = '0;
      cur_amp = '0;
      rhythm_q.delete();
      words_seen = 0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CfgAmpThreshold: regs.amplitude_threshold = cfg_mon.data[ThrW-1:0];
          CfgMinPeakGap:   regs.min_peak_gap_ms = cfg_mon.data;
          CfgMinIndexGap:  regs.min_index_gap = cfg_mon.data[GapW-1:0];
          CfgLongInterval: regs.long_interval_ms = cfg_mon.data;
          CfgFlatLimit:    regs.flatline_limit = cfg_mon.data;
          CfgFlatMinPeaks: regs.flatline_min_peaks = cfg_mon.data[GapW-1:0];
          default: ;
        endcase
      end
      if (smp_mon.valid && smp_mon.ready) begin
        w = {smp_mon.sample_value, smp_mon.sample_time_ms, smp_mon.end_of_record};
        step_rhythm(w, exp_r);
        rhythm_q.push_back(exp_r);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.peak_opened, res_mon.peak_updated, res_mon.peak_total,
               res_mon.peak_time_ms, res_mon.peak_value, res_mon.long_gap_total,
               res_mon.flatline_alarm};
        if (rhythm_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result word %0d with no sample outstanding: %s", words_seen,
                     fmt_result(got));
        end else begin
          exp_r = rhythm_q.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result word %0d expected %s", words_seen, fmt_result(exp_r));
              $display("result word %0d got      %s", words_seen, fmt_result(got));
            end
          end
        end
        words_seen++;
      end
      pending = rhythm_q.size();
    end
  end

endmodule

// File: bench/tb_ecg_r_peak_rhythm_monitor.sv
`timescale 1ns / 1ps

module tb_ecg_r_peak_rhythm_monitor;
  import ecgrpm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int          fail_count;
  int          pending;
  int          items_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;
  logic [31:0] now_ms = '0;

  ecgrpm_cfg_if    cfg_bus ();
  ecgrpm_sample_if sample_bus ();
  ecgrpm_result_if result_bus ();

  ecg_r_peak_rhythm_monitor uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .result_o (result_bus)
  );

  ecgrpm_rhythm_check rhythm_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_mon    (cfg_bus),
    .smp_mon    (sample_bus),
    .res_mon    (result_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (400) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic program_regs(input int thr, input int gap_ms, input int idx_gap,
                              input int long_ms, input int flat_lim, input int min_pk);
    write_reg(CfgAmpThreshold, thr[15:0]);
    write_reg(CfgMinPeakGap, gap_ms[15:0]);
    write_reg(CfgMinIndexGap, idx_gap[15:0]);
    write_reg(CfgLongInterval, long_ms[15:0]);
    write_reg(CfgFlatLimit, flat_lim[15:0]);
    write_reg(CfgFlatMinPeaks, min_pk[15:0]);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] v, input logic [31:0] t, input bit eor);
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.sample_value <= v;
    sample_bus.sample_time_ms <= t;
    sample_bus.end_of_record <= eor;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // advances the record clock, now and then backwards, and marks the odd end of record
  task automatic emit(input int v, input int step_ms);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    if ($urandom_range(0, 49) == 0) now_ms = now_ms - $urandom_range(1, 500);
    else now_ms = now_ms + $urandom_range(0, step_ms);
    send_sample(v[15:0], now_ms, $urandom_range(0, 59) == 0);
  endtask

  task automatic send_beat(input int thr);
    int n_base;
    int n_rise;
    int n_fall;
    int step_ms;
    int lvl;
    n_base = $urandom_range(1, 8);
    n_rise = $urandom_range(1, 4);
    n_fall = $urandom_range(1, 3);
    step_ms = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 2000) : $urandom_range(1, 120);
    for (int i = 0; i < n_base; i++)
      emit(($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 400)) - 200, step_ms);
    lvl = thr;
    for (int i = 0; i < n_rise; i++) begin
      lvl = lvl + int'($urandom_range(1, 3000));
      emit(lvl, step_ms);
    end
    for (int i = 0; i < n_fall; i++) begin
      lvl = lvl - int'($urandom_range(500, 6000));
      emit(lvl, step_ms);
    end
  endtask

  task automatic run_mix(input int upto, input int thr, input int flat_lim, input int noise_pct);
    int pick;
    int run_len;
    while (items_sent < upto) begin
      pick = $urandom_range(1, 100);
      if (pick <= noise_pct) begin
        send_sample(16'($urandom_range(0, 65535)), $urandom, 1'($urandom_range(0, 1)));
      end else if (pick <= noise_pct + 10) begin
        run_len = $urandom_range(1, (flat_lim > 26) ? 30 : flat_lim + 4);
        for (int i = 0; i < run_len; i++) emit(0, 20);
      end else begin
        send_beat(thr);
      end
    end
  endtask

  initial begin
    int thr;
    int flat_lim;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CfgAmpThreshold;
    cfg_bus.data <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.sample_value <= '0;
    sample_bus.sample_time_ms <= '0;
    sample_bus.end_of_record <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: priming word, threshold edge, gap rules, backwards time, end of record
    send_sample(16'sh7FFF, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'sh8000, 32'd0, 1'b0);
    send_sample(16'd1024, 32'd10, 1'b0);
    send_sample(16'd1025, 32'd20, 1'b0);
    send_sample(16'd1100, 32'd40, 1'b0);
    send_sample(16'd0, 32'd60, 1'b0);
    send_sample(16'd2000, 32'd200, 1'b0);
    send_sample(-16'sd5, 32'd210, 1'b0);
    send_sample(-16'sd5, 32'd220, 1'b0);
    send_sample(16'd3000, 32'd255, 1'b0);
    send_sample(16'd0, 32'd260, 1'b0);
    send_sample(16'd0, 32'd270, 1'b0);
    send_sample(16'd5000, 32'd300, 1'b0);
    send_sample(16'd0, 32'd1600, 1'b0);
    send_sample(16'd0, 32'd1700, 1'b0);
    send_sample(16'd6000, 32'd100, 1'b0);
    send_sample(16'd0, 32'd1700, 1'b0);
    send_sample(16'd0, 32'd1800, 1'b0);
    send_sample(16'd7000, 32'd2000, 1'b0);
    send_sample(16'd0, 32'd2100, 1'b0);
    send_sample(16'd0, 32'd2200, 1'b0);
    send_sample(16'd8000, 32'd3500, 1'b1);
    send_sample(16'd0, 32'd3600, 1'b0);
    send_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    now_ms = 32'd4000;

    wait_drained();
    program_regs(500, 20, 3, 300, 5, 2);
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    run_mix(650, 500, 5, 8);

    // everything at zero, with a long hold-off on the result side while words keep coming
    wait_drained();
    program_regs(0, 0, 0, 0, 0, 0);
    tx_idle_pct = 0;
    rx_hold_req = 1'b1;
    run_mix(items_sent + 60, 0, 0, 10);
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    run_mix(1000, 0, 0, 10);

    wait_drained();
    program_regs(32767, 65535, 255, 65535, 65535, 255);
    tx_idle_pct = 20;
    rx_idle_pct = 5;
    run_mix(1200, 32767, 65535, 50);

    wait_drained();
    while (items_sent < 1650) begin
      thr = $urandom_range(0, 32767);
      flat_lim = $urandom_range(0, 24);
      program_regs(thr, $urandom_range(0, 200), $urandom_range(0, 8), $urandom_range(0, 3000),
                   flat_lim, $urandom_range(0, 6));
      tx_idle_pct = $urandom_range(0, 25);
      rx_idle_pct = $urandom_range(0, 25);
      run_mix(items_sent + 90, thr, flat_lim, 6);
      wait_drained();
    end

    program_regs(1024, 30, 1, 800, 3, 1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mix(1950, 1024, 3, 5);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
